// ===== rtl/core/mclp_pkg.sv =====
// ----------------------------------------------------------------------------
// mclp_pkg
// Shared types and constants for the motor command line parser.
// ----------------------------------------------------------------------------
package mclp_pkg;

  localparam int VAL_W     = 16;
  localparam int NUM_SLOTS = 9;

  // slot map of the stored values
  localparam int SLOT_DRIVE  = 0;
  localparam int SLOT_STEER  = 1;
  localparam int SLOT_JOINT1 = 2;

  // ASCII codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;

  // ints per line and first slot of an arm line
  localparam logic [3:0] BASE_INTS     = 4'd2;
  localparam logic [3:0] ARM_INTS      = 4'd7;
  localparam logic [3:0] ARM_SLOT_BASE = 4'd2;

  typedef enum logic [2:0] {
    PH_CMD,
    PH_IGNORE,
    PH_COMMA0,
    PH_INT_START,
    PH_INT_MINUS,
    PH_INT_DIGITS,
    PH_OK,
    PH_FAIL
  } phase_t;

  typedef enum logic [1:0] {
    ST_IGNORED,
    ST_BASE_OK,
    ST_ARM_OK,
    ST_MALFORMED
  } status_t;

  // end-of-line commit request from the parser to the result stage
  typedef struct packed {
    logic                                fire;
    status_t                             status;
    logic [NUM_SLOTS-1:0]                mask;
    logic [NUM_SLOTS-1:0][VAL_W-1:0]     value;
  } commit_t;

endpackage

// ===== rtl/core/mclp_line_parser.sv =====
// ----------------------------------------------------------------------------
// mclp_line_parser
// Per-byte line parse state, pending values and end-of-line commit request.
// ----------------------------------------------------------------------------
module mclp_line_parser import mclp_pkg::*; #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output commit_t    commit
);

  localparam int LEN_W = $clog2(LINE_CAPACITY);

  logic [LEN_W-1:0] len_r, len_nxt;
  phase_t           phase_r, phase_nxt;
  logic             arm_r, arm_nxt;
  logic [2:0]       rel_r, rel_nxt;
  logic             minus_r, minus_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic [VAL_W-1:0] pending_r [NUM_SLOTS];

  logic             is_cr, is_lf, is_digit, room;
  logic [7:0]       c_off;
  logic [3:0]       digit;
  logic [VAL_W-1:0] acc_digit, fin_val;
  logic [3:0]       rel_inc, limit, base_off, slot_fin;
  logic             complete;
  logic             pend_we;

  assign is_cr    = (rx_byte == CH_CR);
  assign is_lf    = (rx_byte == CH_LF);
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign room     = (len_r < LEN_W'(LINE_CAPACITY - 1));
  assign c_off    = rx_byte - CH_ZERO;
  assign digit    = c_off[3:0];
  // acc*10 + digit, modulo 2^16
  assign acc_digit = (acc_r << 3) + (acc_r << 1) + {{(VAL_W-4){1'b0}}, digit};
  assign fin_val   = minus_r ? (~acc_r + {{(VAL_W-1){1'b0}}, 1'b1}) : acc_r;
  assign rel_inc   = {1'b0, rel_r} + 4'd1;
  assign limit     = arm_r ? ARM_INTS : BASE_INTS;
  assign complete  = (rel_inc >= limit);
  assign base_off  = arm_r ? ARM_SLOT_BASE : 4'd0;
  assign slot_fin  = {1'b0, rel_r} + base_off;

  // next state
  always_comb begin
    len_nxt   = len_r;
    phase_nxt = phase_r;
    arm_nxt   = arm_r;
    rel_nxt   = rel_r;
    minus_nxt = minus_r;
    acc_nxt   = acc_r;
    pend_we   = 1'b0;
    if (step && !is_cr) begin
      if (!is_lf && room) begin
        len_nxt = len_r + LEN_W'(1);
        unique case (phase_r)
          PH_CMD: begin
            if (rx_byte == CH_B) begin
              arm_nxt   = 1'b0;
              phase_nxt = PH_COMMA0;
            end else if (rx_byte == CH_A) begin
              arm_nxt   = 1'b1;
              phase_nxt = PH_COMMA0;
            end else begin
              phase_nxt = PH_IGNORE;
            end
          end
          PH_COMMA0: begin
            if (rx_byte == CH_COMMA) begin
              phase_nxt = PH_INT_START;
              minus_nxt = 1'b0;
              acc_nxt   = '0;
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_INT_START, PH_INT_MINUS: begin
            if (phase_r == PH_INT_START && rx_byte == CH_MINUS) begin
              minus_nxt = 1'b1;
              phase_nxt = PH_INT_MINUS;
            end else if (is_digit) begin
              acc_nxt   = {{(VAL_W-4){1'b0}}, digit};
              phase_nxt = PH_INT_DIGITS;
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_INT_DIGITS: begin
            if (is_digit) begin
              acc_nxt = acc_digit;
            end else begin
              // digit run ends: stash the value, then check the ending byte
              pend_we = 1'b1;
              rel_nxt = rel_inc[2:0];
              if (complete) begin
                phase_nxt = (rx_byte == CH_NUL) ? PH_OK : PH_FAIL;
              end else if (rx_byte == CH_COMMA) begin
                phase_nxt = PH_INT_START;
                minus_nxt = 1'b0;
                acc_nxt   = '0;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end
          end
          default: begin
          end
        endcase
      end else begin
        // newline, or overflow: line restarts empty
        len_nxt   = '0;
        phase_nxt = PH_CMD;
        arm_nxt   = 1'b0;
        rel_nxt   = '0;
        minus_nxt = 1'b0;
        acc_nxt   = '0;
      end
    end
  end

  // end-of-line commit request
  always_comb begin
    logic       fin_now;
    logic [2:0] done;
    logic [3:0] rel_of;
    status_t    ok_st;
    fin_now       = 1'b0;
    done          = '0;
    rel_of        = '0;
    ok_st         = arm_r ? ST_ARM_OK : ST_BASE_OK;
    commit.fire   = step && is_lf;
    commit.status = ST_IGNORED;
    unique case (phase_r)
      PH_INT_DIGITS: begin
        fin_now       = 1'b1;
        done          = rel_inc[2:0];
        commit.status = complete ? ok_st : ST_MALFORMED;
      end
      PH_COMMA0, PH_INT_START, PH_INT_MINUS, PH_FAIL: begin
        done          = rel_r;
        commit.status = ST_MALFORMED;
      end
      PH_OK: begin
        done          = rel_r;
        commit.status = ok_st;
      end
      default: begin
        done = '0;
      end
    endcase
    for (int s = 0; s < NUM_SLOTS; s++) begin
      rel_of = 4'(s) - base_off;
      commit.mask[s] = commit.fire && (4'(s) >= base_off) &&
                       (rel_of < {1'b0, done}) && (rel_of < limit);
      commit.value[s] = (fin_now && slot_fin == 4'(s)) ? fin_val : pending_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      phase_r <= PH_CMD;
      arm_r   <= 1'b0;
      rel_r   <= '0;
      minus_r <= 1'b0;
      acc_r   <= '0;
    end else begin
      len_r   <= len_nxt;
      phase_r <= phase_nxt;
      arm_r   <= arm_nxt;
      rel_r   <= rel_nxt;
      minus_r <= minus_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // pending values: no reset, only entries written in this line are read
  always_ff @(posedge clk) begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (pend_we && slot_fin == 4'(s)) begin
        pending_r[s] <= fin_val;
      end
    end
  end

endmodule

// ===== rtl/core/mclp_result_stage.sv =====
// ----------------------------------------------------------------------------
// mclp_result_stage
// Committed command values, result status and the output valid flag.
// ----------------------------------------------------------------------------
module mclp_result_stage import mclp_pkg::*; (
  input  logic                            clk,
  input  logic                            rst_n,
  input  commit_t                         commit,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [NUM_SLOTS-1:0][VAL_W-1:0] values
);

  logic                            valid_r, valid_nxt;
  status_t                         status_r;
  logic [NUM_SLOTS-1:0][VAL_W-1:0] committed_r;

  // commit only fires when the register is free or being drained
  assign valid_nxt = commit.fire ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      committed_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (commit.mask[s]) begin
          committed_r[s] <= commit.value[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit.fire) begin
      status_r <= commit.status;
    end
  end

  assign out_valid  = valid_r;
  assign out_status = status_r;
  assign values     = committed_r;

endmodule

// ===== rtl/core/motor_command_line_parser_unit.sv =====
// ----------------------------------------------------------------------------
// motor_command_line_parser_unit
// Serial command line parser for base drive/steer and seven arm joint speeds.
//
// Feed one received byte per item. Carriage returns are dropped; every
// newline yields exactly one result item carrying a status (0 ignored line,
// 1 base command ok, 2 arm command ok, 3 malformed) and all nine stored
// values. Lines are "B,<drive>,<steer>" or "A,<j1>,...,<j7>"; each int is an
// optional minus and one or more digits, wrapping to 16 bits, and is
// committed at the newline once its digit run has ended, even if the line
// later fails. A zero byte ends the text. A line reaching LINE_CAPACITY-1
// stored bytes drops the next byte and restarts empty with no result. Rate:
// one byte per cycle sustained while the output is not stalled; a byte is
// parsed from the input register, and a parsed newline's result is
// registered into the output register. The input stalls only while a
// result waits in the output register and out_ready is low.
// ----------------------------------------------------------------------------
module motor_command_line_parser_unit import mclp_pkg::*; #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_drive_speed,
  output logic signed [15:0] out_steer_target,
  output logic signed [15:0] out_joint_speed_1,
  output logic signed [15:0] out_joint_speed_2,
  output logic signed [15:0] out_joint_speed_3,
  output logic signed [15:0] out_joint_speed_4,
  output logic signed [15:0] out_joint_speed_5,
  output logic signed [15:0] out_joint_speed_6,
  output logic signed [15:0] out_joint_speed_7
);

  logic                            in_v_r, in_v_nxt;
  logic [7:0]                      in_byte_r;
  logic                            step_ok;   // result register can take a result
  logic                            proc;      // byte in the input register is parsed
  commit_t                         commit;
  logic [NUM_SLOTS-1:0][VAL_W-1:0] values;

  assign step_ok  = !out_valid || out_ready;
  assign proc     = in_v_r && step_ok;
  assign in_ready = !in_v_r || step_ok;
  assign in_v_nxt = (in_valid && in_ready) ? 1'b1 : (proc ? 1'b0 : in_v_r);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // parse state and end-of-line evaluation
  mclp_line_parser #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (proc),
    .rx_byte(in_byte_r),
    .commit (commit)
  );

  // committed values and result register
  mclp_result_stage u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (commit),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_status(out_status),
    .values    (values)
  );

  assign out_drive_speed   = values[SLOT_DRIVE];
  assign out_steer_target  = values[SLOT_STEER];
  assign out_joint_speed_1 = values[SLOT_JOINT1];
  assign out_joint_speed_2 = values[SLOT_JOINT1 + 1];
  assign out_joint_speed_3 = values[SLOT_JOINT1 + 2];
  assign out_joint_speed_4 = values[SLOT_JOINT1 + 3];
  assign out_joint_speed_5 = values[SLOT_JOINT1 + 4];
  assign out_joint_speed_6 = values[SLOT_JOINT1 + 5];
  assign out_joint_speed_7 = values[SLOT_JOINT1 + 6];

  // a parsed newline always yields a result next cycle
  a_lf_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_byte_r == CH_LF |=> out_valid)
    else $error("newline parsed without a result");

  // other bytes never create a result
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_byte_r != CH_LF && !out_valid |=> !out_valid)
    else $error("result raised by a non-newline byte");

  // an ignored line commits nothing
  a_ignored_no_commit: assert property (@(posedge clk) disable iff (!rst_n)
    commit.fire && commit.status == ST_IGNORED |-> commit.mask == '0)
    else $error("ignored line wrote stored values");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_v_r && out_valid && !out_ready)
    else $error("input stalled without a waiting result");

endmodule

// ===== tb/motor_command_line_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// motor_command_line_parser_unit_tb
// Self-checking bench for the serial command line parser. A table of directed
// lines is sent first, then random lines: well-formed base and arm commands,
// broken copies of them, noise, overlong lines and stray carriage returns.
// A line-level model of the parser predicts each result item, which is
// compared field by field with what the block emits.
// ----------------------------------------------------------------------------
module motor_command_line_parser_unit_tb;
  import mclp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_CAP = 64;
  localparam int MAX_REPORTS = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_ITEMS = 1400;
  localparam int MIN_LINES = 20;

  // bit 3 of the field counter marks an arm line
  localparam logic [3:0] ARM_LINE = 4'b1000;

  // markers in the directed text for bytes a string literal cannot hold
  localparam logic [7:0] MARK_NUL = "~";
  localparam logic [7:0] MARK_CR = "^";

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_rx_byte;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_status;
  logic signed [15:0] out_drive_speed;
  logic signed [15:0] out_steer_target;
  logic signed [15:0] out_joint_speed_1;
  logic signed [15:0] out_joint_speed_2;
  logic signed [15:0] out_joint_speed_3;
  logic signed [15:0] out_joint_speed_4;
  logic signed [15:0] out_joint_speed_5;
  logic signed [15:0] out_joint_speed_6;
  logic signed [15:0] out_joint_speed_7;

  motor_command_line_parser_unit #(
    .LINE_CAPACITY(LINE_CAP)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_drive_speed  (out_drive_speed),
    .out_steer_target (out_steer_target),
    .out_joint_speed_1(out_joint_speed_1),
    .out_joint_speed_2(out_joint_speed_2),
    .out_joint_speed_3(out_joint_speed_3),
    .out_joint_speed_4(out_joint_speed_4),
    .out_joint_speed_5(out_joint_speed_5),
    .out_joint_speed_6(out_joint_speed_6),
    .out_joint_speed_7(out_joint_speed_7)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // --------------------------------------------------------------------------
  // Line model: mirrors the parser byte by byte
  // --------------------------------------------------------------------------

  // one result item; vals[0] drive, [1] steer, [2..8] joints 1..7
  typedef struct packed {
    status_t status;
    logic [NUM_SLOTS-1:0][VAL_W-1:0] vals;
  } line_result_t;

  int unsigned line_len;
  phase_t phase;
  logic [3:0] fld;              // ints finished in this line, plus arm flag
  logic neg;
  logic [VAL_W-1:0] mag;
  logic [VAL_W-1:0] pend[NUM_SLOTS];   // ints of the current line
  logic [VAL_W-1:0] stored[NUM_SLOTS]; // what the block reports

  line_result_t results_q[$];   // expected result items, oldest first

  function automatic void clear_line();
    line_len = 0;
    phase = PH_CMD;
    fld = '0;
    neg = 1'b0;
    mag = '0;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // closes a digit run; c is the byte that ended it (NUL at the newline)
  function automatic void end_number(input logic [7:0] c);
    int done;
    int slot;
    logic [VAL_W-1:0] v;
    v = neg ? (16'd0 - mag) : mag;
    done = int'(fld[2:0]);
    slot = (fld[3] ? int'(ARM_SLOT_BASE) : 0) + done;
    pend[slot] = v;
    done++;
    fld[2:0] = done[2:0];
    if (done >= (fld[3] ? int'(ARM_INTS) : int'(BASE_INTS))) begin
      // all ints in: only the end of text may follow
      if (c == CH_NUL) phase = PH_OK;
      else phase = PH_FAIL;
    end else if (c == CH_COMMA) begin
      phase = PH_INT_START;
      neg = 1'b0;
      mag = '0;
    end else begin
      phase = PH_FAIL;
    end
  endfunction

  function automatic void take_char(input logic [7:0] c);
    case (phase)
      PH_CMD: begin
        if (c == CH_B) begin
          fld = '0;
          phase = PH_COMMA0;
        end else if (c == CH_A) begin
          fld = ARM_LINE;
          phase = PH_COMMA0;
        end else begin
          phase = PH_IGNORE;
        end
      end
      PH_COMMA0: begin
        if (c == CH_COMMA) begin
          phase = PH_INT_START;
          neg = 1'b0;
          mag = '0;
        end else begin
          phase = PH_FAIL;
        end
      end
      PH_INT_START, PH_INT_MINUS: begin
        if (phase == PH_INT_START && c == CH_MINUS) begin
          neg = 1'b1;
          phase = PH_INT_MINUS;
        end else if (is_digit(c)) begin
          mag = 16'(c - CH_ZERO);
          phase = PH_INT_DIGITS;
        end else begin
          phase = PH_FAIL;
        end
      end
      PH_INT_DIGITS: begin
        if (is_digit(c)) mag = 16'(mag * 10 + 16'(c - CH_ZERO));
        else end_number(c);
      end
      default: ;
    endcase
  endfunction

  // returns 1 when the byte closes a line, with the result item in res
  function automatic bit predict_byte(input logic [7:0] c, output line_result_t res);
    int done;
    int slot;
    res = '0;
    if (c == CH_CR) return 1'b0;
    if (c != CH_LF) begin
      // a full line drops the byte and starts again from empty
      if (line_len < LINE_CAP - 1) begin
        take_char(c);
        line_len++;
      end else begin
        clear_line();
      end
      return 1'b0;
    end
    if (phase == PH_INT_DIGITS) end_number(CH_NUL);
    else if (phase == PH_COMMA0 || phase == PH_INT_START || phase == PH_INT_MINUS)
      phase = PH_FAIL;
    res.status = ST_IGNORED;
    if (phase == PH_OK || phase == PH_FAIL) begin
      // finished ints are kept even on a malformed line
      done = int'(fld[2:0]);
      for (int i = 0; i < done; i++) begin
        slot = (fld[3] ? int'(ARM_SLOT_BASE) : 0) + i;
        stored[slot] = pend[slot];
      end
      if (phase == PH_FAIL) res.status = ST_MALFORMED;
      else if (fld[3]) res.status = ST_ARM_OK;
      else res.status = ST_BASE_OK;
    end
    clear_line();
    for (int i = 0; i < NUM_SLOTS; i++) res.vals[i] = stored[i];
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  int errors = 0;

  string slot_name[NUM_SLOTS] = '{"drive_speed", "steer_target", "joint_speed_1",
    "joint_speed_2", "joint_speed_3", "joint_speed_4", "joint_speed_5",
    "joint_speed_6", "joint_speed_7"};

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    line_result_t want;
    logic [NUM_SLOTS-1:0][VAL_W-1:0] got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_joint_speed_7, out_joint_speed_6, out_joint_speed_5,
             out_joint_speed_4, out_joint_speed_3, out_joint_speed_2,
             out_joint_speed_1, out_steer_target, out_drive_speed};
      if (results_q.size() == 0) begin
        report_mismatch("unexpected item, status", int'(out_status), 0);
      end else begin
        want = results_q.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", int'(out_status), int'(want.status));
        for (int i = 0; i < NUM_SLOTS; i++)
          if (got[i] !== want.vals[i])
            report_mismatch(slot_name[i], int'($signed(got[i])),
                            int'($signed(want.vals[i])));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int items_sent = 0;     // carriage returns are not counted
  bit typed_on = 1'b0;    // directed row with its status typed in
  status_t typed_st = ST_IGNORED;
  bit typed_zero = 1'b0;  // ... and all values still at reset

  function automatic int pick_burst();
    // now and then a long run with no gaps at all
    if ($urandom_range(0, 9) == 0) return $urandom_range(100, 300);
    return $urandom_range(1, 30);
  endfunction

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    line_result_t r;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (predict_byte(b, r)) begin
      if (typed_on) begin
        r.status = typed_st;
        if (typed_zero) r.vals = '0;
      end
      results_q.push_back(r);
    end
    if (b != CH_CR) items_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = pick_burst();
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall pattern in modes of random length, plus long hold-offs
  // --------------------------------------------------------------------------
  bit hold_req = 1'b0;

  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    out_ready = 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        // long hold-off: the block fills up and must stall its input
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Random line builder
  // --------------------------------------------------------------------------
  logic [7:0] line_buf[$];

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(32, 126));
  endfunction

  // any byte except the line end
  function automatic logic [7:0] rand_filler();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_LF) b = CH_COMMA;
    return b;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void push_number();
    int unsigned n;
    if ($urandom_range(0, 2) == 0) line_buf.push_back(CH_MINUS);
    case ($urandom_range(0, 9))
      0: n = 0;
      1: n = 32767;
      2: n = 32768;
      3: n = 65535;
      4: n = 65536 + $urandom_range(0, 9);
      5, 6: n = $urandom_range(0, 99);
      7: begin
        // leading zeros
        repeat ($urandom_range(1, 3)) line_buf.push_back(CH_ZERO);
        n = $urandom_range(0, 999);
      end
      8: n = $urandom;  // long digit run, wraps several times
      default: n = $urandom_range(0, 65535);
    endcase
    push_text($sformatf("%0d", n));
  endfunction

  function automatic void build_command(input bit arm);
    line_buf.push_back(arm ? CH_A : CH_B);
    for (int k = 0; k < (arm ? int'(ARM_INTS) : int'(BASE_INTS)); k++) begin
      line_buf.push_back(CH_COMMA);
      push_number();
    end
  endfunction

  // break a well-formed command in one of several ways
  function automatic void break_command();
    int pos;
    pos = $urandom_range(0, line_buf.size() - 1);
    case ($urandom_range(0, 4))
      0: while (line_buf.size() > pos) line_buf.pop_back();
      1: line_buf.insert(pos, rand_printable());
      2: line_buf[pos] = rand_printable();
      3: line_buf.push_back(rand_printable());
      default: begin
        line_buf.push_back(CH_COMMA);
        push_number();
      end
    endcase
  endfunction

  function automatic void build_line();
    int kind;
    logic [7:0] b;
    line_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      build_command(1'b0);
    end else if (kind < 65) begin
      build_command(1'b1);
    end else if (kind < 80) begin
      build_command(1'($urandom_range(0, 1)));
      break_command();
    end else if (kind < 88) begin
      // noise, line ends inside it included
      repeat ($urandom_range(0, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 93) begin
      // overlong junk, then a command that should survive the restart
      repeat ($urandom_range(55, 75)) line_buf.push_back(rand_filler());
      build_command(1'($urandom_range(0, 1)));
    end else if (kind < 97) begin
      b = rand_printable();
      if (b == CH_A || b == CH_B) b = CH_COMMA;
      line_buf.push_back(b);
      push_text(",1,2");
    end
    // zero byte ends the text; what follows is ignored
    if ($urandom_range(0, 9) == 0) begin
      line_buf.push_back(CH_NUL);
      repeat ($urandom_range(0, 5)) line_buf.push_back(rand_filler());
    end
    if ($urandom_range(0, 7) == 0)
      line_buf.insert($urandom_range(0, line_buf.size()), CH_CR);
    line_buf.push_back(CH_LF);
  endfunction

  // --------------------------------------------------------------------------
  // Directed lines; status typed in where it is plain, values from the model
  // unless still at reset. '~' stands for a zero byte and '^' for a CR.
  // --------------------------------------------------------------------------
  typedef struct {
    string txt;
    int pad;          // '9' bytes sent ahead of the text
    bit typed;
    status_t st;
    bit zeros;
  } dir_row_t;

  dir_row_t dir_rows[18] = '{
    '{"",                                0,  1'b1, ST_IGNORED,   1'b1},
    '{"X,1,2",                           0,  1'b1, ST_IGNORED,   1'b1},
    '{"~B,1,2",                          0,  1'b1, ST_IGNORED,   1'b1},
    '{"^",                               0,  1'b1, ST_IGNORED,   1'b1},
    '{"B,1",                             0,  1'b1, ST_MALFORMED, 1'b0},
    '{"B,32767,-32768",                  0,  1'b1, ST_BASE_OK,   1'b0},
    '{"A,65535,-1,0,99999,-0,7,-65536",  0,  1'b1, ST_ARM_OK,    1'b0},
    '{"^B,^1,2^",                        0,  1'b1, ST_BASE_OK,   1'b0},
    '{"B,1,2x",                          0,  1'b1, ST_MALFORMED, 1'b0},
    '{"B,3,4~junk",                      0,  1'b0, ST_IGNORED,   1'b0},
    '{"A,11,22",                         0,  1'b1, ST_MALFORMED, 1'b0},
    '{"B,",                              0,  1'b1, ST_MALFORMED, 1'b0},
    '{"B,-",                             0,  1'b1, ST_MALFORMED, 1'b0},
    '{"B-",                              0,  1'b1, ST_MALFORMED, 1'b0},
    '{"B,1,,2",                          0,  1'b1, ST_MALFORMED, 1'b0},
    '{"B,5,6,7",                         0,  1'b1, ST_MALFORMED, 1'b0},
    '{"B,-7,8",                          64, 1'b1, ST_BASE_OK,   1'b0},
    '{"A,9,8,7,6,5,4,3",                 0,  1'b0, ST_IGNORED,   1'b0}
  };

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] ch;
    int lines_sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    clear_line();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      pend[i] = '0;
      stored[i] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    burst_left = pick_burst();

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].pad) send_byte(CH_NINE);
      for (int i = 0; i < dir_rows[r].txt.len(); i++) begin
        ch = dir_rows[r].txt[i];
        if (ch == MARK_NUL) ch = CH_NUL;
        else if (ch == MARK_CR) ch = CH_CR;
        send_byte(ch);
      end
      typed_on = dir_rows[r].typed;
      typed_st = dir_rows[r].st;
      typed_zero = dir_rows[r].zeros;
      send_byte(CH_LF);
      typed_on = 1'b0;
    end

    // random part, until the whole run has sent its share of items
    lines_sent = 0;
    while (items_sent < NUM_ITEMS || lines_sent < MIN_LINES) begin
      if (lines_sent % 25 == 7) hold_req = 1'b1;
      if (lines_sent % 25 == 19) begin
        // let every pending result drain before going on
        in_valid <= 1'b0;
        while (results_q.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      build_line();
      for (int k = 0; k < line_buf.size(); k++) send_byte(line_buf[k]);
      lines_sent++;
    end
    in_valid <= 1'b0;

    wait (results_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
